// ----- design/ash_pkg.sv -----
package ash_pkg;

  localparam int AGE_BUCKETS_DEF = 1024;
  localparam int SIZE_CLASSES    = 12;
  localparam int CLASS_W         = 4;
  localparam int BIG_CLASS       = SIZE_CLASSES - 1;

  localparam logic [31:0] BIG_SIZE = 32'h0000_1000;
  localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48    = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REJECT    = 2'd1;
  localparam logic [1:0] ST_AGE_EMPTY = 2'd2;
  localparam logic [1:0] ST_FUTURE    = 2'd3;

  // Event handed from the control to the statistics registers.
  typedef struct packed {
    logic        accept;
    logic        kind;
    logic [31:0] size;
    logic        future;
    logic        age_empty;
  } stat_cmd_t;

  // Sizes of 4 KiB and up share the top class; below that the class is the
  // position of the highest set bit minus one, and tiny sizes land in class 0.
  function automatic logic [CLASS_W-1:0] size_class(input logic [31:0] sz);
    logic [CLASS_W-1:0] c;
    c = '0;
    for (int b = 2; b <= 11; b++) begin
      if (sz[b]) begin
        c = CLASS_W'(b - 1);
      end
    end
    if (sz >= BIG_SIZE) begin
      c = CLASS_W'(BIG_CLASS);
    end
    return c;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == MAX32) ? v : v + 32'd1;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? MAX32 : s[31:0];
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

endpackage

// ----- design/ash_age_mem.sv -----
module ash_age_mem #(
  parameter int DEPTH = ash_pkg::AGE_BUCKETS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- design/ash_stats.sv -----
module ash_stats (
  input  logic              clk,
  input  logic              rst,
  input  ash_pkg::stat_cmd_t cmd,
  output logic              free_ok,
  output logic [47:0]       live_bytes,
  output logic [31:0]       live_allocations,
  output logic [31:0]       total_allocations,
  output logic [31:0]       rejected_frees,
  output logic [31:0]       age_underruns,
  output logic [31:0]       future_births
);

  import ash_pkg::*;

  logic [31:0]        class_counts [SIZE_CLASSES];
  logic [47:0]        class_bytes  [SIZE_CLASSES];
  logic [CLASS_W-1:0] cls;

  assign cls     = size_class(cmd.size);
  assign free_ok = (live_bytes >= {16'd0, cmd.size}) && (class_counts[cls] != 32'd0) &&
                   (class_bytes[cls] >= {16'd0, cmd.size});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIZE_CLASSES; i++) begin
        class_counts[i] <= '0;
        class_bytes[i]  <= '0;
      end
      live_bytes        <= '0;
      live_allocations  <= '0;
      total_allocations <= '0;
      rejected_frees    <= '0;
      age_underruns     <= '0;
      future_births     <= '0;
    end else begin
      if (cmd.accept) begin
        if (!cmd.kind) begin
          live_bytes        <= sat_add48(live_bytes, cmd.size);
          live_allocations  <= sat_inc32(live_allocations);
          total_allocations <= sat_inc32(total_allocations);
          class_counts[cls] <= sat_inc32(class_counts[cls]);
          class_bytes[cls]  <= sat_add48(class_bytes[cls], cmd.size);
        end else if (free_ok) begin
          live_bytes        <= live_bytes - {16'd0, cmd.size};
          if (live_allocations != 32'd0) begin
            live_allocations <= live_allocations - 32'd1;
          end
          class_counts[cls] <= class_counts[cls] - 32'd1;
          class_bytes[cls]  <= class_bytes[cls] - {16'd0, cmd.size};
          if (cmd.future) begin
            future_births <= sat_inc32(future_births);
            age_underruns <= sat_inc32(age_underruns);
          end
        end else begin
          rejected_frees <= sat_inc32(rejected_frees);
        end
      end
      // An empty bucket is only found later, while no transfer is taken.
      if (cmd.age_empty) begin
        age_underruns <= sat_inc32(age_underruns);
      end
    end
  end

endmodule

// ----- design/alloc_size_age_histogram_core.sv -----
// Allocation statistics: each transfer (start high while busy is low) is one
// allocation or free event, and every event yields exactly one result that is
// shown for a single cycle with done high; the receiver cannot stall, so the
// result must be taken in that cycle. A rejected free, and a free whose birth
// time is in the future with no time advance, give their result in the cycle
// after the transfer. Any other event without a time advance passes through
// S_LOOK and S_UPD, and done is registered from S_UPD. An event whose time lies
// past the last update walks the whole age memory through its read-modify-write
// pipeline (S_SHIFT, S_DRAIN, S_LASTW) before S_LOOK and S_UPD; a free with a
// future birth time skips the bucket update and finishes from S_LASTW. busy is
// low in the cycle in which done is high, so a new event may be started while a
// result is shown. After reset the age memory is cleared one entry per cycle
// with busy high.
module alloc_size_age_histogram_core #(
  parameter int AGE_BUCKETS = ash_pkg::AGE_BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [31:0] size_bytes,
  input  logic [31:0] now_seconds,
  input  logic [31:0] birth_seconds,
  output logic        done,
  output logic [1:0]  status,
  output logic        time_went_back,
  output logic [47:0] live_bytes,
  output logic [31:0] live_allocations,
  output logic [31:0] total_allocations,
  output logic [31:0] rejected_frees,
  output logic [31:0] age_underruns,
  output logic [31:0] future_births
);

  import ash_pkg::*;

  localparam int AW      = $clog2(AGE_BUCKETS);
  localparam int LAST_IX = AGE_BUCKETS - 1;
  localparam logic [AW-1:0] LAST_A = AW'(LAST_IX);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_LASTW = 7'b0010000,
    S_LOOK  = 7'b0100000,
    S_UPD   = 7'b1000000
  } state_t;

  state_t      state;
  logic [AW-1:0] j;
  logic [31:0] last_time;
  logic        done_next;

  logic        kind_q;
  logic        fut_q;
  logic [AW-1:0] ix_q;
  logic [31:0] elapsed;
  logic [31:0] acc;

  logic        p_valid;
  logic        p_first;
  logic        p_acc;
  logic        p_copy;
  logic [AW-1:0] p_j;

  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0] mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [31:0] rd_a;
  logic [31:0] rd_b;

  stat_cmd_t   cmd;
  logic        free_ok;
  logic        accept;
  logic        active;
  logic        now_gt;
  logic [31:0] last_new;
  logic [31:0] age_a;
  logic [AW-1:0] ix_new;
  logic        fut_new;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign active = !kind || free_ok;

  always_comb begin
    now_gt   = now_seconds > last_time;
    last_new = now_gt ? now_seconds : last_time;
    age_a    = last_new - (kind ? birth_seconds : now_seconds);
    ix_new   = (age_a > 32'(LAST_IX)) ? LAST_A : age_a[AW-1:0];
    fut_new  = kind && (birth_seconds > last_new);
  end

  assign cmd.accept    = accept;
  assign cmd.kind      = kind;
  assign cmd.size      = size_bytes;
  assign cmd.future    = fut_new;
  assign cmd.age_empty = (state == S_UPD) && kind_q && (rd_a == 32'd0);

  ash_stats u_stats (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .free_ok           (free_ok),
    .live_bytes        (live_bytes),
    .live_allocations  (live_allocations),
    .total_allocations (total_allocations),
    .rejected_frees    (rejected_frees),
    .age_underruns     (age_underruns),
    .future_births     (future_births)
  );

  // Shift pass: destination j takes old[j - elapsed] on port A, while port B
  // reads old[j] so that everything pushed past the end piles into the
  // catch-all. Writes trail the reads at the registered index p_j, above the reads.
  assign mem_raddr_a = (state == S_SHIFT) ? (j - elapsed[AW-1:0]) : ix_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ix_q;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = j;
      end
      S_SHIFT, S_DRAIN: begin
        mem_we    = p_valid && !p_first;
        mem_waddr = p_j;
        mem_wdata = p_copy ? rd_a : '0;
      end
      S_LASTW: begin
        mem_we    = 1'b1;
        mem_waddr = LAST_A;
        mem_wdata = acc;
      end
      S_UPD: begin
        if (!kind_q) begin
          mem_we    = 1'b1;
          mem_wdata = sat_inc32(rd_a);
        end else begin
          mem_we    = (rd_a != 32'd0);
          mem_wdata = rd_a - 32'd1;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  ash_age_mem #(
    .DEPTH (AGE_BUCKETS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (j),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // A rejected free, or a future birth with no time advance, finishes at once.
  always_comb begin
    case (state)
      S_IDLE:  done_next = accept && (!active || (!now_gt && fut_new));
      S_LASTW: done_next = fut_q;
      S_UPD:   done_next = 1'b1;
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      j         <= '0;
      last_time <= '0;
      done      <= 1'b0;
      p_valid   <= 1'b0;
    end else begin
      done    <= done_next;
      p_valid <= (state == S_SHIFT);
      case (state)
        S_CLEAR: begin
          j <= j + AW'(1);
          if (j == LAST_A) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && active) begin
            if (now_gt) begin
              last_time <= now_seconds;
              j         <= LAST_A;
              state     <= S_SHIFT;
            end else if (!fut_new) begin
              state <= S_LOOK;
            end
          end
        end
        S_SHIFT: begin
          j <= j - AW'(1);
          if (j == '0) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_LASTW;
        end
        S_LASTW: begin
          if (fut_q) begin
            state <= S_IDLE;
          end else begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      kind_q  <= kind;
      fut_q   <= fut_new;
      ix_q    <= ix_new;
      elapsed <= now_seconds - last_time;
      if (!active) begin
        status         <= ST_REJECT;
        time_went_back <= 1'b0;
      end else begin
        status         <= fut_new ? ST_FUTURE : ST_OK;
        time_went_back <= now_seconds < last_time;
      end
    end
    if (state == S_UPD && kind_q && rd_a == 32'd0) begin
      status <= ST_AGE_EMPTY;
    end
    p_j     <= j;
    p_first <= (j == LAST_A);
    p_acc   <= (33'(j) + 33'(elapsed)) >= 33'(LAST_IX);
    p_copy  <= elapsed <= 32'(j);
    if (p_valid) begin
      if (p_first) begin
        acc <= rd_b;
      end else if (p_acc) begin
        acc <= sat_add32(acc, rd_b);
      end
    end
  end

  a_shift_needs_time :
    assert property (@(posedge clk) disable iff (rst) (state == S_SHIFT) |-> (elapsed != 32'd0))
    else $error("shift pass running without elapsed time");

  a_shift_spares_catch_all :
    assert property (@(posedge clk) disable iff (rst)
      ((state == S_SHIFT || state == S_DRAIN) && mem_we) |-> (mem_waddr != LAST_A))
    else $error("shift pass wrote the catch-all bucket");

  a_reject_reported :
    assert property (@(posedge clk) disable iff (rst)
      (accept && kind && !free_ok) |=> (done && status == ST_REJECT))
    else $error("rejected free not reported in the next cycle");

endmodule
